// ===== hw/rtl/complementary_attitude_filter_core_defines.svh =====
// Assertion macros used by the attitude filter port checker.
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_CORE_DEFINES_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("attitude filter check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("attitude filter check failed");

`endif

// ===== hw/rtl/caf_pkg.sv =====
// Constants, register codes and the CORDIC angle table of the attitude filter.
`default_nettype none
package caf_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int TABLE_FRAC       = 24;
  localparam int GY_SH            = 28 - ANGLE_FRAC_BITS;
  localparam int CZ_SH            = TABLE_FRAC - ANGLE_FRAC_BITS;

  localparam int IN_W   = 96;
  localparam int OUT_W  = 80;
  localparam int CFG_W  = 24;

  localparam logic [1:0] REG_BLEND = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;

  localparam logic [15:0] BLEND_RST = 16'd64225;
  localparam logic [23:0] STEP_RST  = 24'd16777;
  localparam logic        MODE_RST  = 1'b0;

  localparam logic signed [30:0] HALF_TURN = 31'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [30:0] FULL_TURN = 31'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [35:0] Z_HALF    = 36'(180) << TABLE_FRAC;
  localparam logic signed [35:0] CZ_RND    = 36'(1) << (CZ_SH - 1);
  localparam logic signed [55:0] GY_RND    = 56'(1) << (GY_SH - 1);
  localparam logic signed [55:0] BL_RND    = 56'(1) << 15;
  localparam logic [47:0]        SQRT_TOP  = 48'h4000_0000_0000;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      5'd24: v = 30'd57;
      5'd25: v = 30'd29;
      5'd26: v = 30'd14;
      5'd27: v = 30'd7;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/complementary_attitude_filter_core.sv =====
// Complementary attitude filter: one IMU sample in, roll/pitch/yaw out.
//
// Usage:
//   in_*  : one transfer carries a sample (three accel counts, three gyro rates).
//   out_* : one transfer per sample carries the updated roll and pitch and the
//           yaw (updated in mode 0 only) in degrees, signed Q9.16, wrapped to [-180, 180).
//   cfg_* : write blend weight, step time or formula mode while idle.
// Timing: the sequencer runs one sample at a time through one shared
//   multiplier, a one-bit-per-cycle square root and one CORDIC stage reused
//   for each atan2 (two per sample). It computes the tilt angles, then
//   updates roll and pitch and, in mode 0 only, yaw, folding each angle into
//   range a turn at a time, and then loads the result. in_tready is low from
//   the input transfer until the cycle after the result is loaded.
// Stall: the result sits in the output register until out_tready; the next
//   sample is already taken in while it waits, and the finished one holds
//   in the sequencer until the register frees.
// Reset (rst_n low, synchronous): angles clear to zero, registers return to
//   their defaults, no result is pending.
`default_nettype none
module complementary_attitude_filter_core #(
  parameter int CORDIC_STEPS = caf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bit each)
  input  wire logic [caf_pkg::IN_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // roll_out, pitch_out, yaw_out (25 bit each), 5 zero bits
  output logic [caf_pkg::OUT_W-1:0]     out_tdata,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [caf_pkg::CFG_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_A, S_SQ_B, S_SQ_SUM, S_SQRT, S_COR_INIT, S_COR_ITER,
    S_COR_DONE, S_GY_MUL, S_GY_ADD, S_BL_MUL_A, S_BL_MUL_B, S_BL_SUM,
    S_WRAP, S_OUT
  } state_t;

  typedef enum logic [1:0] {AX_ROLL, AX_PITCH, AX_YAW} axis_t;

  state_t state_r;
  axis_t  axis_r;

  // configuration
  logic [15:0] w_r;
  logic [23:0] st_r;
  logic        mode_r;

  // sample
  logic signed [15:0] ax_r, ay_r, az_r, rx_r, ry_r, rz_r;

  // angle state
  logic signed [25:0] roll_r, pitch_r, yaw_r;
  logic signed [25:0] acc_roll_r, acc_pitch_r;

  // shared multiplier
  logic signed [29:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [55:0] prod_r;

  // square root
  logic [31:0] sqsum_r;
  logic [47:0] rem_r, root_r, bit_r;
  logic [47:0] trial;
  logic [32:0] sqn;

  // CORDIC
  logic signed [27:0] cx_r, cy_r, cx_in, cy_in, dx, dy;
  logic signed [27:0] ax256, ay256, az256, mag;
  logic signed [35:0] cz_r, tab, z_rnd;
  logic [4:0]         cnt_r;
  logic               call_r;

  // update
  logic signed [29:0] g_r, g_nxt;
  logic signed [55:0] bl_r, gstep_nxt, bl_nxt;
  logic signed [30:0] v_r;
  logic signed [25:0] angle_sel, acc_sel;
  logic signed [15:0] rate_sel, sq_sel;
  logic [16:0]        wc;

  logic                     out_tvalid_r;
  logic [caf_pkg::OUT_W-1:0] out_tdata_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // operand select for the axis under update
  always_comb begin
    unique case (axis_r)
      AX_ROLL: begin
        rate_sel = rx_r; angle_sel = roll_r; acc_sel = acc_roll_r;
      end
      AX_PITCH: begin
        rate_sel = ry_r; angle_sel = pitch_r; acc_sel = acc_pitch_r;
      end
      default: begin
        rate_sel = rz_r; angle_sel = yaw_r; acc_sel = acc_roll_r;
      end
    endcase
  end

  assign sq_sel = mode_r ? ay_r : ax_r;
  assign wc     = 17'h10000 - {1'b0, w_r};

  always_comb begin
    unique case (state_r)
      S_SQ_A:     begin mul_a = 30'(sq_sel);   mul_b = 26'(sq_sel); end
      S_SQ_B:     begin mul_a = 30'(az_r);     mul_b = 26'(az_r);   end
      S_GY_MUL:   begin mul_a = 30'(rate_sel); mul_b = $signed({2'b00, st_r}); end
      S_BL_MUL_A: begin mul_a = g_r;           mul_b = $signed({10'b0, w_r}); end
      S_BL_MUL_B: begin mul_a = 30'(acc_sel);  mul_b = $signed({9'b0, wc}); end
      default:    begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  assign sqn   = {1'b0, sqsum_r} + {1'b0, prod_r[31:0]};
  assign trial = root_r + bit_r;

  assign ax256 = 28'(ax_r) <<< 8;
  assign ay256 = 28'(ay_r) <<< 8;
  assign az256 = 28'(az_r) <<< 8;
  assign mag   = $signed({4'b0, root_r[23:0]});

  // tilt inputs: roll on the first atan2, pitch on the second
  always_comb begin
    if (!call_r) begin
      cy_in = mode_r ? ay256 : -ax256;
      cx_in = az256;
    end else begin
      cy_in = mode_r ? -ax256 : ay256;
      cx_in = mag;
    end
  end

  assign dx    = cy_r >>> cnt_r;
  assign dy    = cx_r >>> cnt_r;
  assign tab   = $signed({6'b0, caf_pkg::atan_deg(cnt_r)});
  assign z_rnd = (cz_r + caf_pkg::CZ_RND) >>> caf_pkg::CZ_SH;

  assign gstep_nxt = (prod_r + caf_pkg::GY_RND) >>> caf_pkg::GY_SH;
  assign g_nxt     = 30'(angle_sel) + gstep_nxt[29:0];
  assign bl_nxt    = (bl_r + prod_r + caf_pkg::BL_RND) >>> 16;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      axis_r       <= AX_ROLL;
      w_r          <= caf_pkg::BLEND_RST;
      st_r         <= caf_pkg::STEP_RST;
      mode_r       <= caf_pkg::MODE_RST;
      roll_r       <= '0;
      pitch_r      <= '0;
      yaw_r        <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      call_r       <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          caf_pkg::REG_BLEND: w_r    <= cfg_wdata[15:0];
          caf_pkg::REG_STEP:  st_r   <= cfg_wdata[23:0];
          caf_pkg::REG_MODE:  mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      // drop the result once the receiver takes it, unless a new one loads
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ax_r <= in_tdata[15:0];
            ay_r <= in_tdata[31:16];
            az_r <= in_tdata[47:32];
            rx_r <= in_tdata[63:48];
            ry_r <= in_tdata[79:64];
            rz_r <= in_tdata[95:80];
            state_r <= S_SQ_A;
          end
        end
        S_SQ_A: state_r <= S_SQ_B;
        S_SQ_B: begin
          sqsum_r <= prod_r[31:0];
          state_r <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          rem_r   <= {sqn[31:0], 16'h0};
          root_r  <= '0;
          bit_r   <= caf_pkg::SQRT_TOP;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            call_r  <= 1'b0;
            state_r <= S_COR_INIT;
          end
        end
        S_COR_INIT: begin
          cnt_r <= '0;
          if (cx_in == '0 && cy_in == '0) begin
            cz_r    <= '0;
            state_r <= S_COR_DONE;
          end else begin
            if (cx_in < 0) begin
              cz_r <= (cy_in >= 0) ? caf_pkg::Z_HALF : -caf_pkg::Z_HALF;
              cx_r <= -cx_in;
              cy_r <= -cy_in;
            end else begin
              cz_r <= '0;
              cx_r <= cx_in;
              cy_r <= cy_in;
            end
            state_r <= S_COR_ITER;
          end
        end
        S_COR_ITER: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + tab;
          end else begin
            cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - tab;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(CORDIC_STEPS - 1)) state_r <= S_COR_DONE;
        end
        S_COR_DONE: begin
          if (!call_r) begin
            acc_roll_r <= z_rnd[25:0];
            call_r     <= 1'b1;
            state_r    <= S_COR_INIT;
          end else begin
            acc_pitch_r <= z_rnd[25:0];
            axis_r      <= AX_ROLL;
            state_r     <= S_GY_MUL;
          end
        end
        S_GY_MUL: state_r <= S_GY_ADD;
        S_GY_ADD: begin
          g_r <= g_nxt;
          if (axis_r == AX_YAW) begin
            v_r     <= 31'(g_nxt) + caf_pkg::HALF_TURN;
            state_r <= S_WRAP;
          end else begin
            state_r <= S_BL_MUL_A;
          end
        end
        S_BL_MUL_A: state_r <= S_BL_MUL_B;
        S_BL_MUL_B: begin
          bl_r    <= prod_r;
          state_r <= S_BL_SUM;
        end
        S_BL_SUM: begin
          v_r     <= bl_nxt[30:0] + caf_pkg::HALF_TURN;
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          // fold one turn per cycle until in range, then store
          if (v_r < 0) begin
            v_r <= v_r + caf_pkg::FULL_TURN;
          end else if (v_r >= caf_pkg::FULL_TURN) begin
            v_r <= v_r - caf_pkg::FULL_TURN;
          end else begin
            unique case (axis_r)
              AX_ROLL: begin
                roll_r  <= 26'(v_r - caf_pkg::HALF_TURN);
                axis_r  <= AX_PITCH;
                state_r <= S_GY_MUL;
              end
              AX_PITCH: begin
                pitch_r <= 26'(v_r - caf_pkg::HALF_TURN);
                axis_r  <= AX_YAW;
                state_r <= mode_r ? S_OUT : S_GY_MUL;
              end
              default: begin
                yaw_r   <= 26'(v_r - caf_pkg::HALF_TURN);
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {5'b0, yaw_r[24:0], pitch_r[24:0], roll_r[24:0]};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/caf_checker.sv =====
// Port-level checker for the attitude filter, bound to the top level.
`default_nettype none
`include "complementary_attitude_filter_core_defines.svh"
module caf_port_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [caf_pkg::OUT_W-1:0] out_tdata
);

  `CAF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CAF_ASSERT_NXT(a_busy_after_in, in_tvalid && in_tready, !in_tready && $stable(out_tdata))
  `CAF_ASSERT_IMP(a_roll_pitch_range, out_tvalid, ($signed(out_tdata[24:0]) >= -caf_pkg::HALF_TURN) && ($signed(out_tdata[24:0]) < caf_pkg::HALF_TURN) && ($signed(out_tdata[49:25]) >= -caf_pkg::HALF_TURN) && ($signed(out_tdata[49:25]) < caf_pkg::HALF_TURN))
  `CAF_ASSERT_IMP(a_yaw_range, out_tvalid, ($signed(out_tdata[74:50]) >= -caf_pkg::HALF_TURN) && ($signed(out_tdata[74:50]) < caf_pkg::HALF_TURN))

endmodule

bind complementary_attitude_filter_core caf_port_checker u_caf_checker (.*);
`default_nettype wire
